// ----- sv/boq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the box occlusion query block.
// No dependencies.
package boq_pkg;

   localparam logic [1:0] REQ_LOAD_DEPTH = 2'd0;
   localparam logic [1:0] REQ_LOAD_CAM   = 2'd1;
   localparam logic [1:0] REQ_QUERY      = 2'd2;

   localparam int CAM_WORDS  = 15;
   localparam int CAM_POS    = 0;
   localparam int CAM_RIGHT  = 3;
   localparam int CAM_NEAR   = 12;
   localparam int CAM_XSCALE = 13;
   localparam int CAM_YSCALE = 14;

   typedef enum logic [1:0] {
      KIND_DEPTH,
      KIND_CAM,
      KIND_QUERY,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [15:0]      index;
      logic [31:0]      value;
      logic [2:0][31:0] box_lo;
      logic [2:0][31:0] box_hi;
   } item_type;

   typedef struct packed {
      logic [8:0] width;
      logic [8:0] height;
   } cfg_type;

   typedef struct packed {
      logic        go;
      logic [63:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        ovf;
      logic [31:0] quot;
      logic [31:0] rem;
   } div_rsp_type;

endpackage

// ----- sv/boq_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module boq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/boq_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on boq_pkg.
module boq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [15:0]       req_index,
   input  logic [31:0]       req_value,
   input  logic [2:0][31:0]  req_box_lo,
   input  logic [2:0][31:0]  req_box_hi,
   input  logic              pop,
   output logic              head_valid,
   output boq_pkg::item_type head
);
   import boq_pkg::*;

   item_type   ent_ff [2];
   item_type   ent_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_new;

   always_comb begin
      item_new.index  = req_index;
      item_new.value  = req_value;
      item_new.box_lo = req_box_lo;
      item_new.box_hi = req_box_hi;
      case (req_type)
         REQ_LOAD_DEPTH: item_new.kind = KIND_DEPTH;
         REQ_LOAD_CAM:   item_new.kind = (req_index < 16'(CAM_WORDS)) ? KIND_CAM : KIND_NOP;
         REQ_QUERY:      item_new.kind = KIND_QUERY;
         default:        item_new.kind = KIND_NOP;
      endcase
   end

   assign busy       = (count_ff == 2'd2);
   assign push       = start && !busy;
   assign head_valid = (count_ff != 2'd0);
   assign head       = ent_ff[rd_ptr_ff];

   always_comb begin
      ent_in    = ent_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         ent_in[wr_ptr_ff] = item_new;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop && head_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      count_in = count_ff + 2'(push) - 2'(pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      ent_ff <= ent_in;
   end
endmodule

// ----- sv/boq_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider, 64 by 32 bits to a 32-bit quotient, one bit per cycle.
// Depends on boq_pkg.
module boq_div (
   input  logic                 clock,
   input  logic                 reset,
   input  boq_pkg::div_req_type req,
   output boq_pkg::div_rsp_type rsp
);
   import boq_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        ovf_ff, ovf_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] quot_ff, quot_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] trial;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, low_ff[31]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (req.go) begin
         // high half at or above the divisor: quotient needs more than 32 bits
         ovf_in  = req.num[63:32] >= req.den;
         rem_in  = req.num[63:32];
         low_in  = req.num[31:0];
         den_in  = req.den;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         quot_in = {quot_ff[30:0], ge};
         low_in  = {low_ff[30:0], 1'b0};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.ovf  = ovf_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;
endmodule

// ----- sv/boq_back.sv -----
`timescale 1ns / 1ps
// Back end: executes loads and box queries (corner transform, projection,
// rectangle clip, grid sampling). Depends on boq_pkg, drives boq_div and boq_ram.
module boq_back #(
   parameter int MAX_WIDTH      = 256,
   parameter int MAX_HEIGHT     = 256,
   parameter int SAMPLE_DIVISOR = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  boq_pkg::cfg_type     cfg,
   input  logic                 head_valid,
   input  boq_pkg::item_type    head,
   output logic                 pop,
   output boq_pkg::div_req_type div_req,
   input  boq_pkg::div_rsp_type div_rsp,
   output logic                 ram_wr_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] ram_wr_addr,
   output logic [31:0]          ram_wr_data,
   output logic                 ram_rd_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] ram_rd_addr,
   input  logic [31:0]          ram_rd_data,
   output logic                 rsp_valid,
   output logic                 rsp_visible,
   output logic                 rsp_was_query
);
   import boq_pkg::*;

   localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW  = $clog2(STORE_WORDS);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int CH  = $clog2(MAX_HEIGHT);
   localparam int DW  = (WW > HW) ? WW : HW;
   localparam int SW  = 34 + DW;
   localparam int RW  = SW - 16;
   localparam int AWW = CH + WW + 1;
   // reciprocals for the constant divides; estimates are at most one low
   localparam longint unsigned ST_RECIP = (64'd1 << 32) / STORE_WORDS;
   localparam int unsigned     SD_RECIP = (32'd1 << 16) / SAMPLE_DIVISOR;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD_WAIT, ST_REL, ST_MUL, ST_ACC, ST_CHECK, ST_NMUL, ST_NGO,
      ST_NWAIT, ST_SCR, ST_UPD, ST_NEXT, ST_RECT, ST_STEPX, ST_STEPY,
      ST_ADDR, ST_CMP
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -50'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // span / SAMPLE_DIVISOR, at least 1
   function automatic logic [15:0] sample_step(input logic [15:0] span);
      logic [31:0] q;
      logic [31:0] r;
      q = (32'(span) * SD_RECIP) >> 16;
      r = 32'(span) - q * 32'(SAMPLE_DIVISOR);
      if (r >= 32'(SAMPLE_DIVISOR)) q = q + 32'd1;
      if (q == 32'd0) q = 32'd1;
      return q[15:0];
   endfunction

   state_type          state_ff, state_in;
   item_type           item_ff, item_in;
   logic signed [31:0] cam_ff [CAM_WORDS];
   logic signed [31:0] cam_in [CAM_WORDS];
   logic [2:0]         corner_ff, corner_in;
   logic signed [31:0] rel_ff [3];
   logic signed [31:0] rel_in [3];
   logic [1:0]         vec_ff, vec_in;
   logic [1:0]         term_ff, term_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [31:0] v_ff [3];
   logic signed [31:0] v_in [3];
   logic               axis_ff, axis_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] ndc_ff [2];
   logic signed [31:0] ndc_in [2];
   logic               any_ff, any_in;
   logic signed [SW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [SW-1:0] min_sx_ff, min_sx_in, max_sx_ff, max_sx_in;
   logic signed [SW-1:0] min_sy_ff, min_sy_in, max_sy_ff, max_sy_in;
   logic signed [31:0] min_d_ff, min_d_in;
   logic [CW-1:0]      x0_ff, x0_in, x1_ff, x1_in, stx_ff, stx_in, px_ff, px_in;
   logic [CH-1:0]      y0_ff, y0_in, y1_ff, y1_in, sty_ff, sty_in, py_ff, py_in;
   logic [15:0]        load_q_ff, load_q_in;
   logic               div_go_ff, div_go_in;
   logic [63:0]        div_num_ff, div_num_in;
   logic [31:0]        div_den_ff, div_den_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_visible_ff, rsp_visible_in;
   logic               rsp_was_query_ff, rsp_was_query_in;

   logic [WW-1:0]      w_eff;
   logic [HW-1:0]      h_eff;
   logic [3:0]         cam_idx;
   logic signed [32:0] diff;
   logic signed [49:0] acc_sum;
   logic signed [32:0] nx_e, ny_e;
   logic signed [RW-1:0] fx0, fx1, fy0, fy1, wm1, hm1, cx0, cx1, cy0, cy1;
   logic [AWW-1:0]     addr_full;
   logic [CW:0]        px_next;
   logic [CH:0]        py_next;
   logic signed [31:0] ndc_sat;
   logic [31:0]        corner_c;
   logic [31:0]        load_rem;

   always_comb begin
      w_eff = (32'(cfg.width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.width);
      h_eff = (32'(cfg.height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.height);
   end

   always_comb begin
      cam_idx = 4'(CAM_RIGHT + 3 * int'(vec_ff) + int'(term_ff));
      acc_sum = acc_ff + 50'(prod_ff >>> 16);
      nx_e    = $signed({ndc_ff[0][31], ndc_ff[0]}) + 33'sd65536;
      ny_e    = 33'sd65536 - $signed({ndc_ff[1][31], ndc_ff[1]});
      fx0     = RW'(min_sx_ff >>> 17);
      fx1     = RW'((max_sx_ff + SW'(131071)) >>> 17);
      fy0     = RW'(min_sy_ff >>> 17);
      fy1     = RW'((max_sy_ff + SW'(131071)) >>> 17);
      wm1     = $signed(RW'(w_eff)) - RW'(1);
      hm1     = $signed(RW'(h_eff)) - RW'(1);
      cx0     = (fx0 < 0) ? RW'(0) : fx0;
      cy0     = (fy0 < 0) ? RW'(0) : fy0;
      cx1     = (fx1 > wm1) ? wm1 : fx1;
      cy1     = (fy1 > hm1) ? hm1 : fy1;
      addr_full = AWW'(py_ff) * AWW'(w_eff) + AWW'(px_ff);
      px_next = {1'b0, px_ff} + {1'b0, stx_ff};
      py_next = {1'b0, py_ff} + {1'b0, sty_ff};
      // load address modulo the store size
      load_rem = 32'(item_ff.index) - 32'(load_q_ff) * 32'(STORE_WORDS);
      if (load_rem >= 32'(STORE_WORDS)) load_rem = load_rem - 32'(STORE_WORDS);
      // truncated quotient, signed, saturated to Q16.16
      if (neg_ff) begin
         ndc_sat = (div_rsp.ovf || div_rsp.quot > 32'h80000000) ? 32'sh80000000
                                                                : -$signed(div_rsp.quot);
      end else begin
         ndc_sat = (div_rsp.ovf || div_rsp.quot[31]) ? 32'sh7FFFFFFF
                                                     : $signed(div_rsp.quot);
      end
   end

   always_comb begin
      state_in         = state_ff;
      item_in          = item_ff;
      cam_in           = cam_ff;
      corner_in        = corner_ff;
      rel_in           = rel_ff;
      vec_in           = vec_ff;
      term_in          = term_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      v_in             = v_ff;
      axis_in          = axis_ff;
      neg_in           = neg_ff;
      ndc_in           = ndc_ff;
      any_in           = any_ff;
      sx_in            = sx_ff;
      sy_in            = sy_ff;
      min_sx_in        = min_sx_ff;
      max_sx_in        = max_sx_ff;
      min_sy_in        = min_sy_ff;
      max_sy_in        = max_sy_ff;
      min_d_in         = min_d_ff;
      x0_in            = x0_ff;
      x1_in            = x1_ff;
      y0_in            = y0_ff;
      y1_in            = y1_ff;
      stx_in           = stx_ff;
      sty_in           = sty_ff;
      px_in            = px_ff;
      py_in            = py_ff;
      load_q_in        = load_q_ff;
      div_go_in        = 1'b0;
      div_num_in       = div_num_ff;
      div_den_in       = div_den_ff;
      rsp_valid_in     = 1'b0;
      rsp_visible_in   = 1'b0;
      rsp_was_query_in = 1'b0;
      pop              = 1'b0;
      ram_wr_en        = 1'b0;
      ram_rd_en        = 1'b0;
      diff             = '0;
      corner_c         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               item_in = head;
               case (head.kind)
                  KIND_DEPTH: begin
                     // quotient estimate by reciprocal; corrected when writing
                     load_q_in = 16'((64'(head.index) * ST_RECIP) >> 32);
                     state_in  = ST_LOAD_WAIT;
                  end
                  KIND_CAM: begin
                     cam_in[head.index[3:0]] = $signed(head.value);
                     rsp_valid_in = 1'b1;
                  end
                  KIND_QUERY: begin
                     corner_in = 3'd0;
                     any_in    = 1'b0;
                     state_in  = ST_REL;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOAD_WAIT: begin
            ram_wr_en    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_REL: begin
            for (int k = 0; k < 3; k++) begin
               corner_c  = corner_ff[k] ? item_ff.box_hi[k] : item_ff.box_lo[k];
               diff      = $signed({corner_c[31], corner_c})
                         - $signed({cam_ff[CAM_POS + k][31], cam_ff[CAM_POS + k]});
               rel_in[k] = sat32(50'(diff));
            end
            vec_in   = 2'd0;
            term_in  = 2'd0;
            acc_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = 64'(rel_ff[term_ff]) * 64'(cam_ff[cam_idx]);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (term_ff == 2'd2) begin
               v_in[vec_ff] = sat32(acc_sum);
               acc_in       = '0;
               term_in      = 2'd0;
               if (vec_ff == 2'd2) begin
                  state_in = ST_CHECK;
               end else begin
                  vec_in   = vec_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end else begin
               acc_in   = acc_sum;
               term_in  = term_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            axis_in  = 1'b0;
            state_in = (v_ff[2] > cam_ff[CAM_NEAR] && v_ff[2] > 0) ? ST_NMUL : ST_NEXT;
         end
         ST_NMUL: begin
            prod_in  = axis_ff ? 64'(v_ff[1]) * 64'(cam_ff[CAM_YSCALE])
                               : 64'(v_ff[0]) * 64'(cam_ff[CAM_XSCALE]);
            state_in = ST_NGO;
         end
         ST_NGO: begin
            neg_in     = prod_ff[63];
            div_num_in = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
            div_den_in = v_ff[2];
            div_go_in  = 1'b1;
            state_in   = ST_NWAIT;
         end
         ST_NWAIT: begin
            if (div_rsp.done) begin
               ndc_in[axis_ff] = ndc_sat;
               if (axis_ff) begin
                  state_in = ST_SCR;
               end else begin
                  axis_in  = 1'b1;
                  state_in = ST_NMUL;
               end
            end
         end
         ST_SCR: begin
            sx_in    = SW'(nx_e) * $signed(SW'(w_eff));
            sy_in    = SW'(ny_e) * $signed(SW'(h_eff));
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!any_ff) begin
               min_sx_in = sx_ff;
               max_sx_in = sx_ff;
               min_sy_in = sy_ff;
               max_sy_in = sy_ff;
               min_d_in  = v_ff[2];
            end else begin
               if (sx_ff < min_sx_ff) min_sx_in = sx_ff;
               if (sx_ff > max_sx_ff) max_sx_in = sx_ff;
               if (sy_ff < min_sy_ff) min_sy_in = sy_ff;
               if (sy_ff > max_sy_ff) max_sy_in = sy_ff;
               if (v_ff[2] < min_d_ff) min_d_in = v_ff[2];
            end
            any_in   = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (corner_ff == 3'd7) begin
               if (any_ff) begin
                  state_in = ST_RECT;
               end else begin
                  rsp_valid_in     = 1'b1;
                  rsp_was_query_in = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               corner_in = corner_ff + 3'd1;
               state_in  = ST_REL;
            end
         end
         ST_RECT: begin
            if (cx0 > cx1 || cy0 > cy1) begin
               rsp_valid_in     = 1'b1;
               rsp_was_query_in = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               x0_in    = cx0[CW-1:0];
               x1_in    = cx1[CW-1:0];
               y0_in    = cy0[CH-1:0];
               y1_in    = cy1[CH-1:0];
               state_in = ST_STEPX;
            end
         end
         ST_STEPX: begin
            stx_in   = CW'(sample_step(16'(x1_ff - x0_ff)));
            state_in = ST_STEPY;
         end
         ST_STEPY: begin
            sty_in   = CH'(sample_step(16'(y1_ff - y0_ff)));
            px_in    = x0_ff;
            py_in    = y0_ff;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            ram_rd_en = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (min_d_ff <= $signed(ram_rd_data)) begin
               rsp_valid_in     = 1'b1;
               rsp_visible_in   = 1'b1;
               rsp_was_query_in = 1'b1;
               state_in         = ST_IDLE;
            end else if (px_next > {1'b0, x1_ff}) begin
               px_in = x0_ff;
               if (py_next > {1'b0, y1_ff}) begin
                  rsp_valid_in     = 1'b1;
                  rsp_was_query_in = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  py_in    = py_next[CH-1:0];
                  state_in = ST_ADDR;
               end
            end else begin
               px_in    = px_next[CW-1:0];
               state_in = ST_ADDR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff          <= item_in;
      cam_ff           <= cam_in;
      corner_ff        <= corner_in;
      rel_ff           <= rel_in;
      vec_ff           <= vec_in;
      term_ff          <= term_in;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      v_ff             <= v_in;
      axis_ff          <= axis_in;
      neg_ff           <= neg_in;
      ndc_ff           <= ndc_in;
      any_ff           <= any_in;
      sx_ff            <= sx_in;
      sy_ff            <= sy_in;
      min_sx_ff        <= min_sx_in;
      max_sx_ff        <= max_sx_in;
      min_sy_ff        <= min_sy_in;
      max_sy_ff        <= max_sy_in;
      min_d_ff         <= min_d_in;
      x0_ff            <= x0_in;
      x1_ff            <= x1_in;
      y0_ff            <= y0_in;
      y1_ff            <= y1_in;
      stx_ff           <= stx_in;
      sty_ff           <= sty_in;
      px_ff            <= px_in;
      py_ff            <= py_in;
      load_q_ff        <= load_q_in;
      div_num_ff       <= div_num_in;
      div_den_ff       <= div_den_in;
      rsp_visible_ff   <= rsp_visible_in;
      rsp_was_query_ff <= rsp_was_query_in;
   end

   assign div_req.go     = div_go_ff;
   assign div_req.num    = div_num_ff;
   assign div_req.den    = div_den_ff;
   assign ram_wr_addr    = load_rem[AW-1:0];
   assign ram_wr_data    = item_ff.value;
   assign ram_rd_addr    = addr_full[AW-1:0];
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_visible    = rsp_visible_ff;
   assign rsp_was_query  = rsp_was_query_ff;
endmodule

// ----- sv/box_occlusion_query.sv -----
`timescale 1ns / 1ps
// Top level of the box occlusion query block: CSR port, front queue, back end,
// divider and depth RAM. Depends on boq_pkg, boq_front, boq_back, boq_div, boq_ram.
//
//  channel   ports                              transfer when
//  request   start, busy, req_*                 start && !busy
//  result    rsp_valid, rsp_visible, rsp_was_*  rsp_valid (one cycle, no backpressure)
//  csr       csr_* (APB style)                  psel && penable && pwrite && pready
//
// Camera load: done in the idle state. Depth load: adds a write state (address wrap by
// reciprocal multiply). Query: per corner a view transform and near check, plus two
// divides with handshake per corner in front, then the rectangle clip and grid samples
// (a RAM read each). The shared 32-step divider sets most of the query time.
// Reset is synchronous; the depth and camera stores are not cleared.
// The two-entry queue accepts requests while the back end works; busy means it is full.
module box_occlusion_query #(
   parameter int MAX_WIDTH      = 256,
   parameter int MAX_HEIGHT     = 256,
   parameter int SAMPLE_DIVISOR = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_index,
   input  logic signed [31:0] req_value,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output logic               rsp_valid,
   output logic               rsp_visible,
   output logic               rsp_was_query
);
   import boq_pkg::*;

   localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(STORE_WORDS);
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   logic [8:0]       width_ff, width_in, height_ff, height_in;
   logic             csr_wr;
   cfg_type          cfg;
   logic             head_valid, pop;
   item_type         head;
   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [31:0]      ram_wr_data, ram_rd_data;
   logic [2:0][31:0] box_lo, box_hi;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr && csr_paddr[2] == REG_WIDTH) width_in = csr_pwdata[8:0];
      if (csr_wr && csr_paddr[2] == REG_HEIGHT) height_in = csr_pwdata[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_prdata = {23'd0, (csr_paddr[2] == REG_HEIGHT) ? height_ff : width_ff};
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

   assign box_lo = {req_box_min_z, req_box_min_y, req_box_min_x};
   assign box_hi = {req_box_max_z, req_box_max_y, req_box_max_x};

   boq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_type   (req_type),
      .req_index  (req_index),
      .req_value  (req_value),
      .req_box_lo (box_lo),
      .req_box_hi (box_hi),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   boq_back #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .SAMPLE_DIVISOR (SAMPLE_DIVISOR)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_visible   (rsp_visible),
      .rsp_was_query (rsp_was_query)
   );

   boq_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   boq_ram #(
      .WIDTH (32),
      .DEPTH (STORE_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   a_load_not_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_was_query |-> !rsp_visible)
      else $error("load result reported visible");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   a_no_write_while_sampling: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> !ram_wr_en)
      else $error("depth write during sampling");
endmodule

// ----- sim/box_occlusion_query_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: directed table, then random loads and box queries under
// sender gaps, checked by an in-bench predictor. Depends on boq_pkg, box_occlusion_query.
module box_occlusion_query_test;
   import boq_pkg::*;

   localparam logic [1:0] REQ_NOP    = 2'd3;
   localparam logic [2:0] CSR_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_HEIGHT = 3'd4;
   localparam longint     ONE        = 65536;
   localparam int         STORE      = 256 * 256;

   typedef struct {
      logic [1:0]       kind;
      logic [15:0]      idx;
      logic [31:0]      val;
      logic [2:0][31:0] lo;
      logic [2:0][31:0] hi;
   } req_item_type;

   typedef struct {
      req_item_type r;
      bit           typed;
      bit           tvis;
   } row_type;

   typedef struct {
      bit vis;
      bit wq;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_type = 0;
   logic [15:0] req_index = 0;
   logic signed [31:0] req_value = 0;
   logic signed [31:0] req_box_min_x = 0, req_box_min_y = 0, req_box_min_z = 0;
   logic signed [31:0] req_box_max_x = 0, req_box_max_y = 0, req_box_max_z = 0;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   logic rsp_valid, rsp_visible, rsp_was_query;

   box_occlusion_query DUT (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [31:0]  depth_mem [STORE];
   bit           depth_written [STORE];
   logic [31:0]  cam_mem [15];
   logic [8:0]   scr_w = 256, scr_h = 256;
   answer_type   answer_q [$];
   longint       sample_addrs [$];
   int           errors = 0;
   int           idle_pct = 0;
   int           items_sent = 0;
   row_type      rows [$];

   task automatic report(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            report("result with nothing expected");
         end else begin
            a = answer_q.pop_front();
            if (rsp_visible !== a.vis)
               report($sformatf("visible %b, expected %b", rsp_visible, a.vis));
            if (rsp_was_query !== a.wq)
               report($sformatf("was_query %b, expected %b", rsp_was_query, a.wq));
         end
      end
   end

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint camw(input int k);
      return longint'($signed(cam_mem[k]));
   endfunction

   function automatic longint view_dot(input longint rel [3], input int base);
      longint s;
      s = 0;
      for (int k = 0; k < 3; k++) s += (rel[k] * camw(base + k)) >>> 16;
      return sat32(s);
   endfunction

   // Returns visibility; with collect set, also lists every grid address it would read.
   function automatic bit box_visible(input req_item_type r, input bit collect);
      longint w, h, nearp, rel [3], vx, vy, vz, nx, ny, sx, sy, c;
      longint minsx, maxsx, minsy, maxsy, mind;
      longint sx0, sx1, sy0, sy1, stx, sty, addr;
      bit any, hit;
      w = scr_w > 256 ? 256 : scr_w;
      h = scr_h > 256 ? 256 : scr_h;
      nearp = camw(CAM_NEAR);
      any = 0;
      hit = 0;
      minsx = 0; maxsx = 0; minsy = 0; maxsy = 0; mind = 0;
      for (int i = 0; i < 8; i++) begin
         for (int k = 0; k < 3; k++) begin
            c = i[k] ? longint'($signed(r.hi[k])) : longint'($signed(r.lo[k]));
            rel[k] = sat32(c - camw(CAM_POS + k));
         end
         vx = view_dot(rel, CAM_RIGHT);
         vy = view_dot(rel, CAM_RIGHT + 3);
         vz = view_dot(rel, CAM_RIGHT + 6);
         if (!(vz > nearp && vz > 0)) continue;
         nx = sat32((vx * camw(CAM_XSCALE)) / vz);
         ny = sat32((vy * camw(CAM_YSCALE)) / vz);
         sx = (nx + ONE) * w;
         sy = (ONE - ny) * h;
         if (!any) begin
            minsx = sx; maxsx = sx; minsy = sy; maxsy = sy; mind = vz;
            any = 1;
         end else begin
            if (sx < minsx) minsx = sx;
            if (sx > maxsx) maxsx = sx;
            if (sy < minsy) minsy = sy;
            if (sy > maxsy) maxsy = sy;
            if (vz < mind) mind = vz;
         end
      end
      if (!any) return 0;
      sx0 = minsx >>> 17;
      sx1 = (maxsx + 131071) >>> 17;
      sy0 = minsy >>> 17;
      sy1 = (maxsy + 131071) >>> 17;
      if (sx0 < 0) sx0 = 0;
      if (sy0 < 0) sy0 = 0;
      if (sx1 > w - 1) sx1 = w - 1;
      if (sy1 > h - 1) sy1 = h - 1;
      if (sx0 > sx1 || sy0 > sy1) return 0;
      stx = (sx1 - sx0) / 4;
      sty = (sy1 - sy0) / 4;
      if (stx < 1) stx = 1;
      if (sty < 1) sty = 1;
      for (longint py = sy0; py <= sy1; py += sty)
         for (longint px = sx0; px <= sx1; px += stx) begin
            addr = (py * w + px) % STORE;
            if (collect) sample_addrs.push_back(addr);
            if (mind <= longint'($signed(depth_mem[addr]))) hit = 1;
         end
      return hit;
   endfunction

   task automatic sender_gap();
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Called at a rising edge; returns at the edge of the transfer (or after a gap).
   task automatic send_req(input req_item_type r, input bit typed = 0, input bit tvis = 0);
      answer_type a;
      start <= 1;
      req_type <= r.kind;
      req_index <= r.idx;
      req_value <= r.val;
      req_box_min_x <= r.lo[0]; req_box_min_y <= r.lo[1]; req_box_min_z <= r.lo[2];
      req_box_max_x <= r.hi[0]; req_box_max_y <= r.hi[1]; req_box_max_z <= r.hi[2];
      do @(posedge clock); while (busy);
      a.vis = 0;
      a.wq = 0;
      case (r.kind)
         REQ_LOAD_DEPTH: begin
            depth_mem[r.idx] = r.val;
            depth_written[r.idx] = 1;
            items_sent++;
         end
         REQ_LOAD_CAM: begin
            if (r.idx < CAM_WORDS) begin
               cam_mem[r.idx] = r.val;
               items_sent++;
            end
         end
         REQ_QUERY: begin
            a.vis = box_visible(r, 0);
            a.wq = 1;
            items_sent++;
         end
         default: ;
      endcase
      if (typed) begin
         a.vis = tvis;
         a.wq = (r.kind == REQ_QUERY);
      end
      answer_q.push_back(a);
      sender_gap();
   endtask

   function automatic logic [31:0] rand_depth();
      if ($urandom_range(9) == 0) return $urandom;
      return $urandom_range(45 * ONE);
   endfunction

   function automatic req_item_type mk(input logic [1:0] kind, input logic [15:0] idx,
                                       input logic [31:0] val,
                                       input logic [31:0] x0 = 0, y0 = 0, z0 = 0,
                                       input logic [31:0] x1 = 0, y1 = 0, z1 = 0);
      req_item_type r;
      r.kind = kind; r.idx = idx; r.val = val;
      r.lo[0] = x0; r.lo[1] = y0; r.lo[2] = z0;
      r.hi[0] = x1; r.hi[1] = y1; r.hi[2] = z1;
      return r;
   endfunction

   // Make sure every grid sample the query can touch holds a written depth first.
   task automatic issue_query(input req_item_type r, input bit typed = 0, input bit tvis = 0);
      longint addrs [$];
      sample_addrs.delete();
      void'(box_visible(r, 1));
      addrs = sample_addrs;
      foreach (addrs[i])
         if (!depth_written[addrs[i]])
            send_req(mk(REQ_LOAD_DEPTH, addrs[i][15:0], rand_depth()));
      send_req(r, typed, tvis);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [8:0] data);
      start <= 0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (1500) @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= addr; csr_pwdata <= {$urandom} & 32'hFFFF_FE00 | data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (addr == CSR_WIDTH) scr_w = data;
      else scr_h = data;
   endtask

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(9) == 0) return $urandom;
      return $signed($urandom_range(60 * ONE)) - 30 * ONE;
   endfunction

   task automatic load_random_camera();
      int yaw;
      logic [31:0] words [15];
      yaw = $urandom_range(3);
      for (int k = 0; k < 3; k++) words[k] = $signed($urandom_range(10 * ONE)) - 5 * ONE;
      for (int k = 3; k < 12; k++) words[k] = 0;
      case (yaw)
         0: begin words[3] = ONE;  words[11] = ONE;  end
         1: begin words[5] = -ONE; words[9] = ONE;   end
         2: begin words[3] = -ONE; words[11] = -ONE; end
         default: begin words[5] = ONE; words[9] = -ONE; end
      endcase
      words[7] = ONE;
      words[12] = $urandom_range(4) == 0 ? -$urandom_range(ONE) : $urandom_range(2 * ONE);
      words[13] = $urandom_range(ONE / 2, 3 * ONE);
      words[14] = $urandom_range(ONE / 2, 3 * ONE);
      if ($urandom_range(4) == 0)
         for (int k = 0; k < 15; k++) if ($urandom_range(2) == 0) words[k] = $urandom;
      for (int k = 0; k < 15; k++) send_req(mk(REQ_LOAD_CAM, k, words[k]));
   endtask

   task automatic random_item();
      int pick;
      logic [31:0] a, b;
      req_item_type r;
      pick = $urandom_range(99);
      if (pick < 12) begin
         send_req(mk(REQ_LOAD_DEPTH, $urandom, rand_depth()));
      end else if (pick < 15) begin
         load_random_camera();
      end else if (pick < 18) begin
         send_req(mk(REQ_LOAD_CAM, $urandom_range(14), $urandom));
      end else if (pick < 20) begin
         send_req(mk(REQ_LOAD_CAM, $urandom_range(65535, 15), $urandom));
      end else if (pick < 22) begin
         send_req(mk(REQ_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom));
      end else begin
         r = mk(REQ_QUERY, $urandom, $urandom);
         for (int k = 0; k < 3; k++) begin
            a = rand_coord();
            b = $urandom_range(9) == 0 ? rand_coord() : a + $urandom_range(8 * ONE);
            r.lo[k] = a;
            r.hi[k] = b;
         end
         issue_query(r);
      end
   endtask

   initial begin
      #60_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [8:0] widths [6];
      logic [8:0] heights [6];
      widths = '{256, 1, 8, 511, 0, 37};
      heights = '{256, 1, 6, 300, 0, 19};

      // camera: origin, identity axes, near 0.5, unit scales
      for (int k = 0; k < 15; k++)
         rows.push_back('{mk(REQ_LOAD_CAM, k,
                              (k == 3 || k == 7 || k == 11 || k >= 13) ? ONE :
                              (k == 12) ? ONE / 2 : 0), 1, 0});
      rows.push_back('{mk(REQ_LOAD_CAM, 15, 32'hFFFF_FFFF), 1, 0});
      rows.push_back('{mk(REQ_LOAD_CAM, 16'hFFFF, 32'h8000_0000), 1, 0});
      rows.push_back('{mk(REQ_LOAD_DEPTH, 16'hFFFF, 32'h7FFF_FFFF), 1, 0});
      rows.push_back('{mk(REQ_LOAD_DEPTH, 0, 32'h8000_0000), 1, 0});
      rows.push_back('{mk(REQ_NOP, 16'hFFFF, '1, '1, '1, '1, '1, '1, '1), 1, 0});
      // box entirely behind the camera
      rows.push_back('{mk(REQ_QUERY, 0, 0, -ONE, -ONE, -10 * ONE, ONE, ONE, -5 * ONE), 1, 0});
      rows.push_back('{mk(REQ_QUERY, 0, 0, -ONE, -ONE, 4 * ONE, ONE, ONE, 6 * ONE), 0, 0});
      rows.push_back('{mk(REQ_QUERY, '1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, 0});
      rows.push_back('{mk(REQ_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, 0});
      rows.push_back('{mk(REQ_QUERY, 0, 0, -ONE / 8, -ONE / 8, ONE, ONE / 8, ONE / 8,
                          2 * ONE), 0, 0});

      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].r.kind == REQ_QUERY) issue_query(rows[i].r, rows[i].typed, rows[i].tvis);
         else send_req(rows[i].r, rows[i].typed, rows[i].tvis);
      end

      items_sent = 0;
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_WIDTH, widths[ph]);
         csr_write(CSR_HEIGHT, heights[ph]);
         idle_pct = ph < 2 ? 38 : (ph < 4 ? 67 : 0);
         while (items_sent < (ph + 1) * 117) random_item();
      end

      start <= 0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (1500) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
